FILE: design/pts_pkg.sv
// Package for the periodic task tick scheduler.
// Holds the command mode codes, the field widths and the controller/datapath link types.
// No dependencies.
package pts_pkg;

    localparam int MODE_W    = 3;
    localparam int ID_W      = 3;
    localparam int TIME_W    = 16;
    localparam int FIRED_W   = 8;
    localparam int MAX_SLOTS = 8;

    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUSPEND = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RESUME  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_KILL    = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;  // A command beat is taken this cycle.
        logic edit;    // The beat edits one slot (any mode other than tick).
        logic step;    // Handle the slot at the walk index.
        logic load;    // Move the finished mask into the output register.
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_last;  // The walk index sits on the last slot.
    } t_dp_sts;

endpackage

FILE: design/pts_dp.sv
// Datapath of the periodic task tick scheduler: slot table, walk index,
// fired mask and output data register. Depends on pts_pkg.
module pts_dp #(
    parameter int NUM_TASKS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pts_pkg::t_dp_cmd             i_cmd,
    output pts_pkg::t_dp_sts             o_sts,
    input  logic [pts_pkg::MODE_W-1:0]   i_mode,
    input  logic [pts_pkg::ID_W-1:0]     i_task_id,
    input  logic [pts_pkg::TIME_W-1:0]   i_period,
    input  logic [pts_pkg::TIME_W-1:0]   i_first_delay,
    input  logic                         i_start_ready,
    output logic [pts_pkg::FIRED_W-1:0]  o_fired_mask
);

    // Only the first eight slots can ever be addressed, so only they are stored.
    localparam int SLOTS = (NUM_TASKS < pts_pkg::MAX_SLOTS) ? NUM_TASKS : pts_pkg::MAX_SLOTS;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TW    = pts_pkg::TIME_W;
    localparam int FW    = pts_pkg::FIRED_W;

    logic [SLOTS-1:0]  r_valid;
    logic [SLOTS-1:0]  r_ready;
    logic [TW-1:0]     r_period    [SLOTS];
    logic [TW-1:0]     r_countdown [SLOTS];
    logic [IDX_W-1:0]  r_idx;
    logic [SLOTS-1:0]  r_mask;
    logic [FW-1:0]     r_out_mask;

    logic              id_ok;
    logic [IDX_W-1:0]  id_slot;
    logic              slot_active;
    logic              slot_zero;

    assign id_ok       = (4'(i_task_id) < 4'(SLOTS));
    assign id_slot     = i_task_id[IDX_W-1:0];
    assign slot_active = r_valid[r_idx] & r_ready[r_idx];
    assign slot_zero   = (r_countdown[r_idx] == '0);

    assign o_sts.walk_last = (r_idx == IDX_W'(SLOTS - 1));
    assign o_fired_mask    = r_out_mask;

    // Valid and ready flags carry the reset state of the table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ready <= '0;
        end else if (i_cmd.edit && id_ok) begin
            unique case (i_mode)
                pts_pkg::MODE_CREATE: begin
                    r_valid[id_slot] <= 1'b1;
                    r_ready[id_slot] <= i_start_ready;
                end
                pts_pkg::MODE_SUSPEND: begin
                    r_ready[id_slot] <= 1'b0;
                end
                pts_pkg::MODE_RESUME: begin
                    r_ready[id_slot] <= 1'b1;
                end
                pts_pkg::MODE_KILL: begin
                    r_valid[id_slot] <= 1'b0;
                    r_ready[id_slot] <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Period and countdown matter only while a slot is valid, and create
    // always rewrites both, so they need no reset or clearing on kill.
    always_ff @(posedge i_clk) begin
        if (i_cmd.edit && id_ok && (i_mode == pts_pkg::MODE_CREATE)) begin
            r_period[id_slot]    <= i_period;
            r_countdown[id_slot] <= i_first_delay;
        end
        if (i_cmd.step && slot_active) begin
            if (slot_zero) begin
                r_countdown[r_idx] <= r_period[r_idx] - TW'(1);
            end else begin
                r_countdown[r_idx] <= r_countdown[r_idx] - TW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx  <= '0;
            r_mask <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + IDX_W'(1);
            if (slot_active && slot_zero) begin
                r_mask[r_idx] <= 1'b1;
            end
        end
        if (i_cmd.load) begin
            r_out_mask <= FW'(r_mask);
        end
    end

endmodule

FILE: design/pts_ctrl.sv
// Controller of the periodic task tick scheduler: the command sequencer
// and the output valid flag. Depends on pts_pkg.
module pts_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [pts_pkg::MODE_W-1:0]  i_mode,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output pts_pkg::t_dp_cmd            o_cmd,
    input  pts_pkg::t_dp_sts            i_sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;
    logic       load;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid & o_in_ready;
    assign load        = (r_state == ST_DONE) & (~r_out_valid | i_out_ready);
    assign o_out_valid = r_out_valid;

    assign o_cmd.accept = accept;
    assign o_cmd.edit   = accept & (i_mode != pts_pkg::MODE_TICK);
    assign o_cmd.step   = (r_state == ST_WALK);
    assign o_cmd.load   = load;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_mode == pts_pkg::MODE_TICK) ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK: begin
                if (i_sts.walk_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: design/periodic_task_tick_scheduler.sv
// Top level of the periodic task tick scheduler.
// Instantiates pts_ctrl and pts_dp; uses pts_pkg for codes and link types.
//
// Usage: each beat on the command channel (i_in_valid / o_in_ready) carries
// one command: a tick, or a create, suspend, resume or kill of one slot.
// Every command yields exactly one beat on the result channel
// (o_out_valid / i_out_ready) carrying o_fired_mask, where bit i is set when
// slot i fired on that tick. Non-tick commands return a zero mask, and a
// command naming a slot beyond NUM_TASKS changes nothing.
// An edit command goes straight to the done state after acceptance.
// A tick walks the slot table one slot per cycle through a single
// countdown decrement/reload unit, then its mask is loaded into the output
// register; a new command is taken once the previous one has been handed to
// the output register.
// Only the first eight slots are held, since no command can address others.
// Reset clears every slot's valid and ready flag and the output valid flag,
// not the output data; no clearing pass is needed. When the receiver stalls,
// the finished result waits in the output register, the next command is still
// accepted and processed, and its result then waits until the register frees.
module periodic_task_tick_scheduler #(
    parameter int NUM_TASKS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [pts_pkg::MODE_W-1:0]   i_mode,
    input  logic [pts_pkg::ID_W-1:0]     i_task_id,
    input  logic [pts_pkg::TIME_W-1:0]   i_period,
    input  logic [pts_pkg::TIME_W-1:0]   i_first_delay,
    input  logic                         i_start_ready,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [pts_pkg::FIRED_W-1:0]  o_fired_mask
);

    pts_pkg::t_dp_cmd dp_cmd;
    pts_pkg::t_dp_sts dp_sts;

    // The controller sequences each command and owns the output valid flag.
    pts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    // The datapath holds the slot table and builds the fired mask.
    pts_dp #(
        .NUM_TASKS (NUM_TASKS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_mode        (i_mode),
        .i_task_id     (i_task_id),
        .i_period      (i_period),
        .i_first_delay (i_first_delay),
        .i_start_ready (i_start_ready),
        .o_fired_mask  (o_fired_mask)
    );

endmodule
